// File: design/uf2bt_pkg.sv
`timescale 1ns / 1ps

package uf2bt_pkg;

  // UF2 header constants
  localparam logic [31:0] MAGIC_START0 = 32'h0A32_4655;
  localparam logic [31:0] MAGIC_START1 = 32'h9E5D_5157;
  localparam logic [31:0] MAGIC_END    = 32'h0AB1_6F30;
  localparam int          FLAG_FAMILY_BIT  = 13;
  localparam int          FLAG_NOFLASH_BIT = 0;
  localparam logic [8:0]  PAYLOAD_MAX  = 9'd476;

  // configuration register indexes
  localparam int          CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAMILY_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BASE = 2'd1;

  // input tdata layout, lowest bit first
  localparam int IN_M0_LO    = 0;
  localparam int IN_M1_LO    = 32;
  localparam int IN_ME_LO    = 64;
  localparam int IN_FLAGS_LO = 96;
  localparam int IN_TADDR_LO = 128;
  localparam int IN_PSIZE_LO = 160;
  localparam int IN_BNUM_LO  = 169;
  localparam int IN_TBLK_LO  = 201;
  localparam int IN_FAM_LO   = 233;
  localparam int IN_TDATA_W  = 272;

  // output tdata layout, lowest bit first
  localparam int OUT_ACC_BIT   = 0;
  localparam int OUT_ADDR_LO   = 1;
  localparam int OUT_LEN_LO    = 33;
  localparam int OUT_NEWLY_BIT = 42;
  localparam int OUT_FLUSH_BIT = 43;
  localparam int OUT_IMG_LO    = 44;
  localparam int OUT_USED_W    = 76;
  localparam int OUT_TDATA_W   = 80;

endpackage

// File: design/uf2_block_tracker_unit.sv
`timescale 1ns / 1ps
// UF2 block tracker. Each input transfer carries one UF2 block header; the unit
// checks the three magic words, the family-present and no-flash flags and the
// family against family_id, and returns one result transfer per header: the
// accept flag, the flash address (write_base + target address), the saturated
// write length, whether the block number was new, a flush request once all
// expected blocks are in, and the running image length. The seen-block bitmap
// lives in a synchronous memory of (MAX_BLOCK_COUNT+7)/8 byte rows. The bitmap
// row of a header is read as the header is taken; the calculation state then
// modifies and writes back the row and loads the result register. The input
// channel is held off in that state, which waits for the result register to be
// free, so no header is taken before the previous one is through. A header may
// be taken while the previous result still waits at the output. After reset the
// unit clears the bitmap one row per cycle and accepts no header until the last
// row is cleared; configuration writes are taken at any time and must only be
// issued while the unit is idle.
module uf2_block_tracker_unit
  import uf2bt_pkg::*;
#(
  parameter int MAX_BLOCK_COUNT = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data,
  // header input; tdata from bit 0: magic_start0, magic_start1, magic_end,
  // block_flags, target_address, payload_size, block_number, total_blocks,
  // block_family, zero fill
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result output; tdata from bit 0: accepted, flash_address, write_length,
  // newly_marked, flush_request, image_length, zero fill
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int BM_ROWS = (MAX_BLOCK_COUNT + 7) / 8;
  localparam int AW      = $clog2(BM_ROWS);
  localparam int EW      = $clog2(MAX_BLOCK_COUNT);
  localparam int WCW     = $clog2(MAX_BLOCK_COUNT + 1);
  localparam logic [AW-1:0] LAST_ROW = AW'(BM_ROWS - 1);
  localparam logic [31:0]   MAX_CNT  = 32'(MAX_BLOCK_COUNT);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CALC} state_t;

  // configuration registers
  logic [31:0] family_id_r, write_base_r;

  // control and tracker state
  state_t         state_r, state_nxt;
  logic [AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [EW-1:0]  exp_cnt_r, exp_cnt_nxt;
  logic           cnt_inv_r, cnt_inv_nxt;
  logic [WCW-1:0] wr_cnt_r, wr_cnt_nxt;
  logic [31:0]    total_len_r, total_len_nxt;
  logic           out_valid_r, out_valid_nxt;

  // header held between the read and the write-back cycle
  logic           ok_r, ok_nxt;
  logic [8:0]     len_r, len_nxt;
  logic [31:0]    addr_r, addr_nxt;
  logic           track_r, track_nxt;
  logic           in_range_r, in_range_nxt;
  logic           tb_big_r, tb_big_nxt;
  logic [EW-1:0]  tb_low_r, tb_low_nxt;
  logic [AW-1:0]  row_r, row_nxt;
  logic [2:0]     bit_r, bit_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // bitmap memory
  logic [7:0]    bm_mem [BM_ROWS];
  logic [7:0]    rd_row_r;
  logic          mem_rd_en, mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  // header fields
  logic [31:0] h_m0, h_m1, h_me, h_flags, h_taddr, h_bnum, h_tblk, h_fam;
  logic [8:0]  h_psize;

  assign h_m0    = in_tdata[IN_M0_LO    +: 32];
  assign h_m1    = in_tdata[IN_M1_LO    +: 32];
  assign h_me    = in_tdata[IN_ME_LO    +: 32];
  assign h_flags = in_tdata[IN_FLAGS_LO +: 32];
  assign h_taddr = in_tdata[IN_TADDR_LO +: 32];
  assign h_psize = in_tdata[IN_PSIZE_LO +: 9];
  assign h_bnum  = in_tdata[IN_BNUM_LO  +: 32];
  assign h_tblk  = in_tdata[IN_TBLK_LO  +: 32];
  assign h_fam   = in_tdata[IN_FAM_LO   +: 32];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // read the bitmap row for the header being taken
  assign mem_rd_en = in_tvalid && in_tready;

  logic           commit, seen, newly, flush;
  logic           cnt_ne;
  logic [7:0]     bit_mask;
  logic [31:0]    addr_o;
  logic [8:0]     len_o;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    exp_cnt_nxt   = exp_cnt_r;
    cnt_inv_nxt   = cnt_inv_r;
    wr_cnt_nxt    = wr_cnt_r;
    total_len_nxt = total_len_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ok_nxt        = ok_r;
    len_nxt       = len_r;
    addr_nxt      = addr_r;
    track_nxt     = track_r;
    in_range_nxt  = in_range_r;
    tb_big_nxt    = tb_big_r;
    tb_low_nxt    = tb_low_r;
    row_nxt       = row_r;
    bit_nxt       = bit_r;
    mem_we        = 1'b0;
    mem_waddr     = row_r;
    bit_mask      = 8'b1 << bit_r;
    mem_wdata     = rd_row_r | bit_mask;
    seen          = rd_row_r[bit_r];
    cnt_ne        = tb_big_r || (tb_low_r != exp_cnt_r);
    newly         = 1'b0;
    flush         = 1'b0;
    commit        = (state_r == S_CALC) && (!out_valid_r || out_tready);
    addr_o        = ok_r ? addr_r : 32'd0;
    len_o         = ok_r ? len_r : 9'd0;

    // drop the result once the sink takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = 8'd0;
        if (clr_addr_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          ok_nxt = (h_m0 == MAGIC_START0) && (h_m1 == MAGIC_START1) &&
                   (h_me == MAGIC_END) && h_flags[FLAG_FAMILY_BIT] &&
                   !h_flags[FLAG_NOFLASH_BIT] && (h_fam == family_id_r);
          len_nxt      = (h_psize > PAYLOAD_MAX) ? PAYLOAD_MAX : h_psize;
          addr_nxt     = write_base_r + h_taddr;
          track_nxt    = (h_tblk != 32'd0);
          in_range_nxt = (h_bnum < MAX_CNT);
          tb_big_nxt   = (h_tblk >= MAX_CNT);
          tb_low_nxt   = h_tblk[EW-1:0];
          row_nxt      = h_bnum[AW+2:3];
          bit_nxt      = h_bnum[2:0];
          state_nxt    = S_CALC;
        end
      end
      S_CALC: begin
        if (commit) begin
          if (ok_r) begin
            total_len_nxt = total_len_r + 32'(len_r);
            if (track_r) begin
              // latch the expected count, or mark it unusable
              if (!cnt_inv_r && cnt_ne) begin
                if (tb_big_r || (exp_cnt_r != '0)) begin
                  cnt_inv_nxt = 1'b1;
                end else begin
                  exp_cnt_nxt = tb_low_r;
                end
              end
              if (in_range_r) begin
                if (!seen) begin
                  mem_we     = 1'b1;
                  wr_cnt_nxt = wr_cnt_r + WCW'(1);
                  newly      = 1'b1;
                end
                flush = !cnt_inv_nxt && (wr_cnt_nxt >= WCW'(exp_cnt_nxt));
              end
            end
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_TDATA_W - OUT_USED_W)'(0), total_len_nxt, flush, newly,
                           len_o, addr_o, ok_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      exp_cnt_r    <= '0;
      cnt_inv_r    <= 1'b0;
      wr_cnt_r     <= '0;
      total_len_r  <= '0;
      out_valid_r  <= 1'b0;
      family_id_r  <= '0;
      write_base_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      cnt_inv_r   <= cnt_inv_nxt;
      wr_cnt_r    <= wr_cnt_nxt;
      total_len_r <= total_len_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FAMILY_ID:  family_id_r  <= cfg_data;
          CFG_WRITE_BASE: write_base_r <= cfg_data;
          default: ;
        endcase
      end
    end
    out_data_r <= out_data_nxt;
    ok_r       <= ok_nxt;
    len_r      <= len_nxt;
    addr_r     <= addr_nxt;
    track_r    <= track_nxt;
    in_range_r <= in_range_nxt;
    tb_big_r   <= tb_big_nxt;
    tb_low_r   <= tb_low_nxt;
    row_r      <= row_nxt;
    bit_r      <= bit_nxt;
  end

  // bitmap: one write port, one registered read port; the write-back lands
  // before the next header's read, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bm_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_rd_en) begin
      rd_row_r <= bm_mem[h_bnum[AW+2:3]];
    end
  end

endmodule

// File: design/uf2bt_checker.sv
`timescale 1ns / 1ps

module uf2bt_checker
  import uf2bt_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // one header at a time: input held off in the cycle after a transfer
  a_one_at_a_time: assert property (@(posedge clk)
    in_tvalid && in_tready |=> !in_tready)
    else $error("header taken while previous one still in work");

  // a rejected block reports nothing but the image length
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_ACC_BIT] |->
      out_tdata[OUT_ADDR_LO +: 32] == 32'd0 && out_tdata[OUT_LEN_LO +: 9] == 9'd0 &&
      !out_tdata[OUT_NEWLY_BIT] && !out_tdata[OUT_FLUSH_BIT])
    else $error("rejected block carries write data");

  // write length never exceeds the UF2 payload limit
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_LEN_LO +: 9] <= PAYLOAD_MAX)
    else $error("write length above payload limit");

endmodule

bind uf2_block_tracker_unit uf2bt_checker u_uf2bt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
